### rtl/core/pwlt_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear table lookup package
// Table sizes, fixed-point format constants and command codes shared by the
// lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FRAC_BITS   = 30;

	// Command codes carried on func.
	localparam logic [1:0] FUNC_WR_BP  = 2'd0;
	localparam logic [1:0] FUNC_WR_LVL = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

endpackage

`default_nettype wire

### rtl/core/piecewise_linear_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// Piecewise linear table lookup unit
// Holds a breakpoint table and a level table and answers return period
// queries by stepwise or linear interpolation with a shared divider and
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. Table writes
// (func 0 and 1) complete in that same cycle and give no result. A query
// (func 2) gives one result on level_out / level_out_valid, marked by a
// one-cycle strobe; the receiver cannot stall it.
// A query with a missing period or missing first level answers in the cycle
// after the request, without going busy. Otherwise the block searches the
// breakpoint table one entry per cycle, then in interpolate mode runs a
// restoring divider for a 31-bit quotient, two multiplier passes and a
// rounding step. Step mode, a zero gap and a period above the last
// breakpoint answer right after the search. busy stays high until the
// result is shown; the next request can be taken in the cycle the strobe
// is high.
// Reset clears the sequencer, the cell valid flag and the configuration
// registers (interpolate mode on, sixteen entries). Table contents are not
// cleared; they are undefined until written.
// Configuration goes through the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_lookup_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         func,
	input  wire  [3:0]         entry_index,
	input  wire  signed [31:0] sample_value,
	input  wire                sample_valid,
	output logic signed [31:0] level_out,
	output logic               level_out_valid,
	output logic               strobe,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [2:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pwlt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_MUL_LO = 3'd3;
	localparam logic [2:0] S_MUL_HI = 3'd4;
	localparam logic [2:0] S_ROUND  = 3'd5;

	localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

	// Configuration
	logic             mode_q;
	logic [4:0]       count_q;
	logic             cfg_wr;

	// Tables
	logic [31:0]        bp_mem [TABLE_DEPTH];
	logic signed [31:0] lv_mem [TABLE_DEPTH];
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_in_range;
	logic [IDX_W-1:0]   rd_addr;
	logic [31:0]        bp_rd_q;
	logic signed [31:0] lv_rd_q;

	// Sequencer
	logic [2:0]         state_q;
	logic               accept;
	logic               cell_valid_q;
	logic [31:0]        p_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   n_clamped;
	logic [CNT_W-1:0]   k_q;
	logic               rd_ok_q;
	logic [31:0]        bp_prev_q;
	logic signed [31:0] lv_prev_q;
	logic               hit;
	logic [31:0]        gap;

	// Shared divider and multiplier
	logic [32:0]        rem_q;
	logic [31:0]        den_q;
	logic [30:0]        quo_q;
	logic [4:0]         div_cnt_q;
	logic               div_ge;
	logic [32:0]        div_sub;
	logic [32:0]        div_next;
	logic signed [32:0] diff_q;
	logic signed [31:0] lo_q;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [63:0] acc_q;
	logic signed [63:0] rnd_sum;
	logic signed [63:0] rnd_shift;
	logic signed [31:0] level_rnd;

	// Outputs
	logic signed [31:0] level_out_q;
	logic               level_out_valid_q;
	logic               strobe_q;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			count_q <= 5'd16;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MODE:  mode_q  <= pwdata[0];
				REG_COUNT: count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE:  prdata = {31'd0, mode_q};
			REG_COUNT: prdata = {27'd0, count_q};
			default:   prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Table memories
	// ------------------------------------------------------------------
	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign wr_addr     = IDX_W'(entry_index);
	assign wr_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
	assign rd_addr     = k_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && wr_in_range && func == FUNC_WR_BP) begin
			bp_mem[wr_addr] <= $unsigned(sample_value);
		end
		if (accept && wr_in_range && func == FUNC_WR_LVL) begin
			lv_mem[wr_addr] <= sample_value;
		end
		bp_rd_q <= bp_mem[rd_addr];
		lv_rd_q <= lv_mem[rd_addr];
	end

	// A count of zero is taken as one, and any count above the depth as the depth.
	always_comb begin
		if (count_q == 5'd0) begin
			n_clamped = CNT_W'(1);
		end else if (32'(count_q) > 32'(TABLE_DEPTH)) begin
			n_clamped = CNT_W'(TABLE_DEPTH);
		end else begin
			n_clamped = CNT_W'(count_q);
		end
	end

	// ------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------
	assign hit = (p_q <= bp_rd_q);
	assign gap = bp_rd_q - bp_prev_q;

	assign div_sub  = rem_q - {1'b0, den_q};
	assign div_ge   = (rem_q >= {1'b0, den_q});
	assign div_next = div_ge ? div_sub : rem_q;

	assign mul_b = (state_q == S_MUL_LO) ? $signed({1'b0, quo_q[15:0]})
	                                     : $signed({2'b00, quo_q[30:16]});
	assign mul_p = diff_q * mul_b;

	assign rnd_sum   = acc_q + ROUND_HALF;
	assign rnd_shift = rnd_sum >>> FRAC_BITS;
	assign level_rnd = lo_q + $signed(rnd_shift[31:0]);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cell_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
			rd_ok_q      <= 1'b0;
			k_q          <= '0;
			div_cnt_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_WR_LVL: begin
								if (wr_in_range && entry_index == 4'd0) begin
									cell_valid_q <= sample_valid;
								end
							end
							FUNC_QUERY: begin
								if (!sample_valid || !cell_valid_q) begin
									level_out_q       <= '0;
									level_out_valid_q <= 1'b0;
									strobe_q          <= 1'b1;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							default: ;
						endcase
					end
					p_q       <= $unsigned(sample_value);
					n_q       <= n_clamped;
					k_q       <= '0;
					rd_ok_q   <= 1'b0;
					bp_prev_q <= '0;
					lv_prev_q <= '0;
				end

				// bp_rd_q and lv_rd_q hold entry k_q - 1 once rd_ok_q is set.
				S_SEARCH: begin
					k_q     <= k_q + CNT_W'(1);
					rd_ok_q <= 1'b1;
					if (rd_ok_q) begin
						if (hit) begin
							if (!mode_q) begin
								level_out_q       <= lv_prev_q;
								level_out_valid_q <= 1'b1;
								strobe_q          <= 1'b1;
								state_q           <= S_IDLE;
							end else if (gap == 32'd0) begin
								level_out_q       <= lv_rd_q;
								level_out_valid_q <= 1'b1;
								strobe_q          <= 1'b1;
								state_q           <= S_IDLE;
							end else begin
								rem_q     <= {1'b0, p_q - bp_prev_q};
								den_q     <= gap;
								diff_q    <= 33'(lv_rd_q) - 33'(lv_prev_q);
								lo_q      <= lv_prev_q;
								div_cnt_q <= 5'(FRAC_BITS);
								state_q   <= S_DIV;
							end
						end else begin
							bp_prev_q <= bp_rd_q;
							lv_prev_q <= lv_rd_q;
							// No breakpoint at or above the period: hold the last level.
							if (k_q == n_q) begin
								level_out_q       <= lv_rd_q;
								level_out_valid_q <= 1'b1;
								strobe_q          <= 1'b1;
								state_q           <= S_IDLE;
							end
						end
					end
				end

				// Restoring division, one quotient bit per cycle, MSB first.
				S_DIV: begin
					rem_q     <= {div_next[31:0], 1'b0};
					quo_q     <= {quo_q[29:0], div_ge};
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_cnt_q == 5'd0) begin
						state_q <= S_MUL_LO;
					end
				end

				S_MUL_LO: begin
					acc_q   <= 64'(mul_p);
					state_q <= S_MUL_HI;
				end

				S_MUL_HI: begin
					acc_q   <= acc_q + (64'(mul_p) <<< 16);
					state_q <= S_ROUND;
				end

				S_ROUND: begin
					level_out_q       <= level_rnd;
					level_out_valid_q <= 1'b1;
					strobe_q          <= 1'b1;
					state_q           <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign level_out       = level_out_q;
	assign level_out_valid = level_out_valid_q;
	assign strobe          = strobe_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result strobe while a request is still in progress");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (k_q <= n_q))
		else $error("breakpoint search ran past the entries in use");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_QUERY && sample_valid && cell_valid_q) |=> busy)
		else $error("valid query did not start the sequencer");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == 5'd0) |=> (state_q == S_MUL_LO))
		else $error("divider did not hand over to the multiplier");

endmodule

`default_nettype wire

### tb/tb_piecewise_linear_table_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear table lookup unit testbench
// Loads the breakpoint and level tables through write requests and checks
// every query result against a fixed-point predictor of the lookup. The
// configuration is rewritten over the APB port between phases while idle.
// ----------------------------------------------------------------------------

module tb_piecewise_linear_table_lookup_unit;

	import pwlt_pkg::*;

	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam int         DRAIN_CYCLES = 64;
	localparam int         CYCLE_LIMIT  = 500000;
	localparam int         RANDOM_ITEMS = 480;
	localparam int         QUIET_ITEMS  = 80;

	typedef struct packed {
		logic [31:0] level;
		logic        valid;
	} lookup_result_t;

	// Keeps its own copy of the tables and registers and predicts each query.
	class lookup_scoreboard;
		logic [31:0]    bp_table [TABLE_DEPTH];
		logic [31:0]    lvl_table [TABLE_DEPTH];
		logic           cell_valid;
		logic           interp_mode;
		logic [4:0]     bp_count;
		lookup_result_t expected_results [$];
		int             errors;

		function new();
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				bp_table[k]  = '0;
				lvl_table[k] = '0;
			end
			cell_valid  = 1'b0;
			interp_mode = 1'b1;
			bp_count    = 5'd16;
			errors      = 0;
		endfunction

		function void write_register(logic reg_idx, logic [31:0] data);
			if (reg_idx == REG_MODE) begin
				interp_mode = data[0];
			end else begin
				bp_count = data[4:0];
			end
		endfunction

		// Moves from lo toward hi by num/den with a 30-bit fraction, rounded.
		function logic [31:0] blend(logic [31:0] lo, logic [31:0] hi,
				logic [31:0] num, logic [31:0] den);
			logic [63:0] frac;
			int          lo_s;
			int          hi_s;
			longint      diff;
			longint      prod;
			longint      q;
			longint      sum;
			if (den == 32'd0) begin
				return hi;
			end
			lo_s = lo;
			hi_s = hi;
			frac = ({32'd0, num} << FRAC_BITS) / {32'd0, den};
			diff = longint'(hi_s) - longint'(lo_s);
			prod = diff * longint'(frac);
			q    = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			sum  = longint'(lo_s) + q;
			return sum[31:0];
		endfunction

		function lookup_result_t predict_query(logic [31:0] period, logic period_ok);
			lookup_result_t r;
			int             n;
			int             i;
			r.level = '0;
			r.valid = 1'b0;
			if (!period_ok || !cell_valid) begin
				return r;
			end
			n = int'(bp_count);
			if (n < 1) begin
				n = 1;
			end
			if (n > TABLE_DEPTH) begin
				n = TABLE_DEPTH;
			end
			i = n;
			for (int k = n - 1; k >= 0; k--) begin
				if (period <= bp_table[k]) begin
					i = k;
				end
			end
			r.valid = 1'b1;
			if (interp_mode) begin
				if (i == 0) begin
					r.level = blend('0, lvl_table[0], period, bp_table[0]);
				end else if (i < n) begin
					r.level = blend(lvl_table[i-1], lvl_table[i], period - bp_table[i-1],
						bp_table[i] - bp_table[i-1]);
				end else begin
					r.level = lvl_table[n-1];
				end
			end else begin
				r.level = (i == 0) ? '0 : lvl_table[i-1];
			end
			return r;
		endfunction

		function void note_request(logic [1:0] f, logic [3:0] idx, logic [31:0] value,
				logic ok);
			case (f)
				FUNC_WR_BP: begin
					bp_table[idx] = value;
				end
				FUNC_WR_LVL: begin
					lvl_table[idx] = value;
					if (idx == 4'd0) begin
						cell_valid = ok;
					end
				end
				FUNC_QUERY: begin
					expected_results.push_back(predict_query(value, ok));
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void check_result(logic [31:0] level, logic valid);
			lookup_result_t want;
			if (expected_results.size() == 0) begin
				$error("result with no request waiting: level_out %h, level_out_valid %b",
					level, valid);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (level !== want.level) begin
				$error("level_out mismatch: expected %h, actual %h", want.level, level);
				errors++;
			end
			if (valid !== want.valid) begin
				$error("level_out_valid mismatch: expected %b, actual %b", want.valid, valid);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  func = FUNC_WR_BP;
	logic [3:0]  entry_index = '0;
	logic [31:0] sample_value = '0;
	logic        sample_valid = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;

	logic        busy;
	logic [31:0] level_out;
	logic        level_out_valid;
	logic        strobe;
	logic [31:0] prdata;
	logic        pready;

	lookup_scoreboard sb;
	int               items_sent = 0;
	int               cycle_count = 0;
	bit               idling_on = 1'b0;

	piecewise_linear_table_lookup_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.entry_index     (entry_index),
		.sample_value    (sample_value),
		.sample_valid    (sample_valid),
		.level_out       (level_out),
		.level_out_valid (level_out_valid),
		.strobe          (strobe),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_result(level_out, level_out_valid);
		end
	end

	task automatic sender_gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(input logic [1:0] f, input logic [3:0] idx,
			input logic [31:0] value, input logic ok);
		start        <= 1'b1;
		func         <= f;
		entry_index  <= idx;
		sample_value <= value;
		sample_valid <= ok;
		do @(posedge clk); while (busy);
		sb.note_request(f, idx, value, ok);
		items_sent++;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			sender_gap($urandom_range(1, 10));
		end
	endtask

	// Wait for every outstanding query result, then stay idle a while longer.
	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(reg_idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Styles 0 to 2 give sorted breakpoints with small, medium and wide
	// spacing; style 3 leaves them unsorted.
	task automatic load_tables(input int style);
		logic [32:0] acc;
		logic [31:0] value;
		int          step_max;
		case (style)
			0: begin
				acc      = 33'($urandom_range(0, 255));
				step_max = 4;
			end
			1: begin
				acc      = 33'($urandom_range(0, 1 << 16));
				step_max = 1 << 16;
			end
			default: begin
				acc      = 33'($urandom & 32'h7FFF_FFFF);
				step_max = 1 << 27;
			end
		endcase
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (style == 3) begin
				value = $urandom;
			end else begin
				value = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
			end
			send_request(FUNC_WR_BP, 4'(k), value, 1'($urandom_range(0, 1)));
			acc = acc + 33'($urandom_range(0, step_max));
		end
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			value = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF);
			send_request(FUNC_WR_LVL, 4'(k), value, 1'b1);
		end
	endtask

	function automatic logic [31:0] pick_period();
		int          k;
		logic [31:0] lo_bp;
		logic [31:0] hi_bp;
		logic [31:0] gap;
		k     = $urandom_range(0, TABLE_DEPTH - 1);
		lo_bp = sb.bp_table[k];
		hi_bp = (k < TABLE_DEPTH - 1) ? sb.bp_table[k+1] : 32'hFFFF_FFFF;
		gap   = hi_bp - lo_bp;
		case ($urandom_range(0, 7))
			0: return lo_bp;
			1: return lo_bp - 32'd1;
			2: return lo_bp + 32'd1;
			3, 4: return lo_bp + ((gap == 32'hFFFF_FFFF) ? $urandom : $urandom % (gap + 32'd1));
			5: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_item();
		int          pick;
		logic [3:0]  idx;
		logic [31:0] value;
		pick = $urandom_range(0, 99);
		idx  = 4'($urandom_range(0, TABLE_DEPTH - 1));
		if (pick < 75) begin
			send_request(FUNC_QUERY, 4'($urandom), pick_period(), $urandom_range(0, 9) != 0);
		end else if (pick < 85) begin
			value = $urandom_range(0, 1) ? $urandom : pick_period();
			send_request(FUNC_WR_BP, idx, value, 1'($urandom_range(0, 1)));
		end else if (pick < 95) begin
			send_request(FUNC_WR_LVL, idx, $urandom,
				(idx == 4'd0) ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1)));
		end else begin
			send_request(FUNC_UNUSED, 4'($urandom), $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input int phase);
		logic [4:0] mode_presets [5];
		logic [4:0] count_presets [5];
		logic       mode;
		logic [4:0] count;
		mode_presets  = '{5'd0, 5'd1, 5'd0, 5'd1, 5'd1};
		count_presets = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17};
		if (phase < 5) begin
			mode  = mode_presets[phase][0];
			count = count_presets[phase];
		end else begin
			mode  = 1'($urandom_range(0, 1));
			count = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
			                                     : 5'($urandom_range(1, 16));
		end
		wait_drained();
		apb_write(REG_MODE, {31'd0, mode});
		apb_write(REG_COUNT, {27'd0, count});
		if ($urandom_range(0, 2) == 0) begin
			load_tables($urandom_range(0, 3));
		end
		repeat ($urandom_range(15, 40)) random_item();
	endtask

	initial begin
		int          phase;
		int          random_start;
		logic [31:0] bp_value;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No level written yet, so the cell is invalid and no table is read.
		send_request(FUNC_QUERY, 4'd0, 32'd100, 1'b1);

		// Evenly spaced breakpoints, k+1 times 2^27.
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			bp_value = 32'(k + 1);
			send_request(FUNC_WR_BP, 4'(k), bp_value << 27, 1'($urandom_range(0, 1)));
		end
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			send_request(FUNC_WR_LVL, 4'(k), $urandom, 1'b1);
		end

		send_request(FUNC_QUERY, 4'd0, 32'h0000_0000, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h0800_0000, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h0400_0000, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h2800_0001, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h4FFF_FFFF, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'hFFFF_FFFF, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h8000_0000, 1'b1);

		// Full-scale level swing across one segment, both directions.
		send_request(FUNC_WR_LVL, 4'd6, 32'h8000_0000, 1'b1);
		send_request(FUNC_WR_LVL, 4'd7, 32'h7FFF_FFFF, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h3C00_0000, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h3800_0001, 1'b1);
		send_request(FUNC_WR_LVL, 4'd6, 32'h7FFF_FFFF, 1'b1);
		send_request(FUNC_WR_LVL, 4'd7, 32'h8000_0000, 1'b1);
		send_request(FUNC_QUERY, 4'd0, 32'h3C00_0000, 1'b1);

		// Missing period.
		send_request(FUNC_QUERY, 4'd0, 32'h4000_0000, 1'b0);

		// A zero first breakpoint with a zero period leaves a zero gap.
		send_request(FUNC_WR_BP, 4'd0, 32'h0000_0000, 1'b0);
		send_request(FUNC_QUERY, 4'd0, 32'h0000_0000, 1'b1);
		send_request(FUNC_WR_BP, 4'd0, 32'h0800_0000, 1'b1);

		send_request(FUNC_UNUSED, 4'($urandom), $urandom, 1'b1);

		// Missing first level invalidates the cell until it is rewritten.
		send_request(FUNC_WR_LVL, 4'd0, $urandom, 1'b0);
		send_request(FUNC_QUERY, 4'd0, 32'h0400_0000, 1'b1);
		send_request(FUNC_WR_LVL, 4'd0, $urandom, 1'b1);

		idling_on    = 1'b1;
		phase        = 0;
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (RANDOM_ITEMS - (items_sent - random_start) <= QUIET_ITEMS) begin
				idling_on = 1'b0;
			end
			run_phase(phase);
			phase++;
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
